>>> hw/rtl/compacting_array_list_defines.svh
// assertion macros for the compacting array list
`ifndef COMPACTING_ARRAY_LIST_DEFINES_SVH
`define COMPACTING_ARRAY_LIST_DEFINES_SVH

`ifndef SYNTHESIS
`define CAL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CAL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CAL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CAL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/cal_pkg.sv
package cal_pkg;

  localparam int unsigned LIST_CAPACITY = 16;
  localparam int unsigned WORD_WIDTH    = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCNT_W  = 5;

  localparam int unsigned CNT_W = $clog2(LIST_CAPACITY + 1);
  localparam int unsigned IDX_W = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int unsigned S_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((VAL_W + STAT_W + OCNT_W + 1 + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_READ_AT   = 3'd2,
    OP_READ_HEAD = 3'd3,
    OP_READ_TAIL = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } cal_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value_out;
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] entry_count;
    logic              is_empty;
  } cal_result_t;

endpackage

>>> hw/rtl/cal_ctrl.sv
`include "compacting_array_list_defines.svh"

module cal_ctrl
  import cal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cal_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.load  = in_ready_o && in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);

  // an accepted item is executed next cycle and then offered
  `CAL_ASSERT_NXT(a_load_then_exec, clk_i, rst_ni, cmd_o.load, cmd_o.exec)
  `CAL_ASSERT_NXT(a_exec_then_out, clk_i, rst_ni, cmd_o.exec, out_valid_o && !in_ready_o)
  `CAL_ASSERT_IMP(a_no_load_while_busy, clk_i, rst_ni, out_valid_o || cmd_o.exec, !cmd_o.load)

endmodule

>>> hw/rtl/cal_datapath.sv
`include "compacting_array_list_defines.svh"

module cal_datapath
  import cal_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cal_cmd_t          cmd_i,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [VAL_W-1:0]  value_in_i,
  output cal_result_t       result_o
);

  logic [OP_W-1:0]       op_q;
  logic [POS_W-1:0]      pos_q;
  logic [WORD_WIDTH-1:0] word_q;

  logic [WORD_WIDTH-1:0] entries_q [LIST_CAPACITY];
  logic [WORD_WIDTH-1:0] entries_d [LIST_CAPACITY];
  logic [CNT_W-1:0]      count_q, count_d;
  cal_result_t           result_q, result_d;

  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic                  is_full, is_zero, pos_bad;
  logic                  do_append, do_remove;
  logic [IDX_W-1:0]      rd_idx;
  logic [WORD_WIDTH-1:0] rd_word;
  logic [WORD_WIDTH-1:0] rd_val;
  status_e               status;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      pos_q  <= position_i;
      word_q <= WORD_WIDTH'(value_in_i);
    end
  end

  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count_q);
  assign is_full = (count_q == CNT_W'(LIST_CAPACITY));
  assign is_zero = (count_q == '0);
  assign pos_bad = (pos_ext >= cnt_ext);

  always_comb begin
    status    = ST_OK;
    do_append = 1'b0;
    do_remove = 1'b0;
    rd_idx    = '0;
    rd_val    = '0;
    unique case (op_q)
      OP_APPEND: begin
        if (is_full) status = ST_FULL;
        else do_append = 1'b1;
      end
      OP_REMOVE: begin
        if (is_zero) status = ST_EMPTY;
        else if (pos_bad) status = ST_BADIDX;
        else do_remove = 1'b1;
      end
      OP_READ_AT: begin
        rd_idx = IDX_W'(pos_q);
        if (pos_bad) status = ST_BADIDX;
        else rd_val = rd_word;
      end
      OP_READ_HEAD: begin
        rd_idx = '0;
        if (is_zero) status = ST_EMPTY;
        else rd_val = rd_word;
      end
      OP_READ_TAIL: begin
        rd_idx = IDX_W'(count_q - CNT_W'(1));
        if (is_zero) status = ST_EMPTY;
        else rd_val = rd_word;
      end
      default: begin
      end
    endcase
  end

  assign rd_word = entries_q[rd_idx];

  // compaction: every entry at or above the index, but the top one, takes its upper neighbour
  always_comb begin
    for (int k = 0; k < LIST_CAPACITY; k++) begin
      entries_d[k] = entries_q[k];
      if (do_append && (CNT_W'(k) == count_q)) begin
        entries_d[k] = word_q;
      end
      if (do_remove && (k + 1 < LIST_CAPACITY) && (CMP_W'(k) >= pos_ext)) begin
        entries_d[k] = entries_q[(k + 1) % LIST_CAPACITY];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_append) count_d = count_q + CNT_W'(1);
    else if (do_remove) count_d = count_q - CNT_W'(1);
  end

  always_comb begin
    result_d.value_out   = VAL_W'(rd_val);
    result_d.status      = status;
    result_d.entry_count = OCNT_W'(count_d);
    result_d.is_empty    = (count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      result_q  <= result_d;
    end
  end

  assign result_o = result_q;

  `CAL_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(LIST_CAPACITY))
  `CAL_ASSERT_NXT(a_count_idle, clk_i, rst_ni, !cmd_i.exec, $stable(count_q))
  `CAL_ASSERT_IMP(a_one_update, clk_i, rst_ni, 1'b1, !(do_append && do_remove))

endmodule

>>> hw/rtl/compacting_array_list.sv
// compacting array list: a store of up to sixteen 32-bit words held in
// order at places 0 .. count-1. each request item appends a word, removes
// the word at an index (the words above it move down one place in the same
// cycle), or reads the word at an index, the first word or the last word.
// every request gives exactly one result item with the word read (zero when
// nothing is read), a status (ok, full, empty, bad index), the count after
// the request and an empty flag. a request is captured at acceptance, runs
// in the execute state in the register array datapath, and its result is
// offered from the next cycle on and held until taken; the next request is
// taken in the cycle after the result has been accepted, so no new request
// is taken while one is in flight or its result waits on m_axis_tready_i.
module compacting_array_list
  import cal_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // position, value_in, zero pad
  input  logic [OP_W-1:0]      s_axis_tuser_i,  // operation
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o   // value_out, status, entry_count, is_empty
);

  cal_cmd_t    cmd;
  cal_result_t result;

  cal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  cal_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .operation_i (s_axis_tuser_i),
    .position_i  (s_axis_tdata_i[POS_W-1:0]),
    .value_in_i  (s_axis_tdata_i[POS_W+VAL_W-1:POS_W]),
    .result_o    (result)
  );

  assign m_axis_tdata_o = M_TDATA_W'({result.is_empty, result.entry_count,
                                      result.status, result.value_out});

endmodule

>>> sim/list_checker.sv
module list_checker
  import cal_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_ready_i,
  input  logic [S_TDATA_W-1:0] s_data_i,   // position, value_in, zero pad
  input  logic [OP_W-1:0]      s_user_i,   // operation
  input  logic                 m_valid_i,
  input  logic                 m_ready_i,
  input  logic [M_TDATA_W-1:0] m_data_i,   // value_out, status, entry_count, is_empty
  output int                   error_count_o,
  output int                   awaited_count_o
);

  logic [WORD_WIDTH-1:0] shadow_words [LIST_CAPACITY];
  int unsigned           shadow_fill;
  cal_result_t           awaited_results [$];

  function automatic cal_result_t apply_request(input logic [OP_W-1:0]  op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] word);
    cal_result_t r;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (shadow_fill >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      OP_REMOVE: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= shadow_fill) begin
          r.status = ST_BADIDX;
        end else begin
          for (int k = pos; k + 1 < shadow_fill; k++) shadow_words[k] = shadow_words[k + 1];
          shadow_fill--;
        end
      end
      OP_READ_AT: begin
        if (pos >= shadow_fill) r.status = ST_BADIDX;
        else r.value_out = shadow_words[pos];
      end
      OP_READ_HEAD: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else r.value_out = shadow_words[0];
      end
      OP_READ_TAIL: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else r.value_out = shadow_words[shadow_fill - 1];
      end
      default: ;
    endcase
    r.entry_count = shadow_fill[OCNT_W-1:0];
    r.is_empty    = (shadow_fill == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cal_result_t want;
    cal_result_t got;
    if (!rst_ni) begin
      shadow_fill = 0;
      for (int k = 0; k < LIST_CAPACITY; k++) shadow_words[k] = '0;
      awaited_results.delete();
      error_count_o   = 0;
      awaited_count_o = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        awaited_results.push_back(apply_request(s_user_i, s_data_i[POS_W-1:0],
                                                s_data_i[POS_W+VAL_W-1:POS_W]));
      end
      if (m_valid_i && m_ready_i) begin
        got.value_out   = m_data_i[VAL_W-1:0];
        got.status      = m_data_i[VAL_W+STAT_W-1:VAL_W];
        got.entry_count = m_data_i[VAL_W+STAT_W+OCNT_W-1:VAL_W+STAT_W];
        got.is_empty    = m_data_i[VAL_W+STAT_W+OCNT_W];
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual %0h", $time, got);
          error_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("value_out", want.value_out, got.value_out);
          check_field("status", VAL_W'(want.status), VAL_W'(got.status));
          check_field("entry_count", VAL_W'(want.entry_count), VAL_W'(got.entry_count));
          check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(got.is_empty));
        end
      end
      awaited_count_o = awaited_results.size();
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  import cal_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 400;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [OP_W-1:0]      s_user = '0;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic [M_TDATA_W-1:0] m_data;

  int error_count;
  int awaited_count;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  compacting_array_list DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  list_checker list_watch (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_valid_i       (s_valid),
    .s_ready_i       (s_ready),
    .s_data_i        (s_data),
    .s_user_i        (s_user),
    .m_valid_i       (m_valid),
    .m_ready_i       (m_ready),
    .m_data_i        (m_data),
    .error_count_o   (error_count),
    .awaited_count_o (awaited_count)
  );

  // result side back-pressure, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {{(S_TDATA_W-POS_W-VAL_W){1'b0}}, word, pos};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random_phase(input int n_items);
    int roll;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] word;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (((i / 40) % 2) == 0) begin
        // filling stretch
        if (roll < 55) op = OP_APPEND;
        else if (roll < 65) op = OP_REMOVE;
        else if (roll < 80) op = OP_READ_AT;
        else if (roll < 87) op = OP_READ_HEAD;
        else if (roll < 96) op = OP_READ_TAIL;
        else op = OP_SPARE_LO + OP_W'($urandom_range(2));
      end else begin
        // draining stretch
        if (roll < 20) op = OP_APPEND;
        else if (roll < 60) op = OP_REMOVE;
        else if (roll < 78) op = OP_READ_AT;
        else if (roll < 86) op = OP_READ_HEAD;
        else if (roll < 96) op = OP_READ_TAIL;
        else op = OP_SPARE_LO + OP_W'($urandom_range(2));
      end
      pos = ($urandom_range(1) == 0) ? POS_W'($urandom_range(3)) : POS_W'($urandom_range(15));
      roll = $urandom_range(9);
      if (roll == 0) word = '0;
      else if (roll == 1) word = '1;
      else word = $urandom;
      offer_request(op, pos, word);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 16;
    recv_idle_pct <= 46;

    // empty list corners
    offer_request(OP_READ_HEAD, 4'd0, 32'h0);
    offer_request(OP_READ_TAIL, 4'd0, 32'h0);
    offer_request(OP_READ_AT, 4'd0, 32'h0);
    offer_request(OP_REMOVE, 4'd15, 32'h0);
    offer_request(OP_SPARE_LO + 3'd2, 4'd15, 32'hffff_ffff);
    // fill to capacity, then one more
    offer_request(OP_APPEND, 4'd0, 32'h0);
    offer_request(OP_APPEND, 4'd15, 32'hffff_ffff);
    offer_request(OP_APPEND, 4'd0, 32'h8000_0001);
    for (int i = 0; i < 13; i++) offer_request(OP_APPEND, POS_W'($urandom_range(15)), $urandom);
    offer_request(OP_APPEND, 4'd7, 32'h5a5a_a5a5);
    offer_request(OP_READ_AT, 4'd15, 32'h0);
    // remove last, first, then indexes past the count
    offer_request(OP_REMOVE, 4'd15, 32'h0);
    offer_request(OP_REMOVE, 4'd0, 32'h0);
    offer_request(OP_READ_AT, 4'd14, 32'h0);
    offer_request(OP_REMOVE, 4'd14, 32'h0);

    run_random_phase(PHASE_ITEMS);

    send_idle_pct = 46;
    recv_idle_pct <= 16;
    run_random_phase(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_token <= hold_token + 1;
    run_random_phase(PHASE_ITEMS);

    s_valid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
